@@ sv/rcfd_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and channel conditioning functions for the remote frame decoder
// no dependencies; imported by every rcfd module and the top level

package rcfd_pkg;

   // frame layout
   localparam logic [7:0] HEADER_BYTE = 8'hAA;
   localparam logic [3:0] POS_HUNT    = 4'd0;
   localparam logic [3:0] POS_LAST    = 4'd9;
   localparam int         NUM_CHAN    = 4;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_OFFSET  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STICK_LIMIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THROTTLE_BASE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THROTTLE_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THROTTLE_FLOOR = 3'd5;

   // register reset values
   localparam logic [15:0] RST_CENTER_OFFSET  = 16'd1500;
   localparam logic [9:0]  RST_STICK_LIMIT    = 10'd500;
   localparam logic [9:0]  RST_DEAD_ZONE      = 10'd50;
   localparam logic [15:0] RST_THROTTLE_BASE  = 16'd1000;
   localparam logic [10:0] RST_THROTTLE_LIMIT = 11'd1000;
   localparam logic [10:0] RST_THROTTLE_FLOOR = 11'd100;

   // result payload width, padded to whole bytes
   localparam int CHAN_W     = 11;
   localparam int RSP_DATA_W = 48;

   typedef struct packed {
      logic [15:0] center_offset;
      logic [9:0]  stick_limit;
      logic [9:0]  dead_zone;
      logic [15:0] throttle_base;
      logic [10:0] throttle_limit;
      logic [10:0] throttle_floor;
   } cfg_type;

   typedef logic [15:0] raw_type;

   // one completed frame handed from the framer to the conditioning stage
   typedef struct packed {
      logic                   good;
      raw_type [NUM_CHAN-1:0] raw;
   } frame_type;

   // conditioned channels, channel zero in the lowest bits
   typedef struct packed {
      logic signed [CHAN_W-1:0] chan_three;
      logic        [CHAN_W-1:0] chan_two;
      logic signed [CHAN_W-1:0] chan_one;
      logic signed [CHAN_W-1:0] chan_zero;
   } chan_type;

   // stick channel: remove center, clamp to +-limit, zero inside the dead zone
   function automatic logic signed [CHAN_W-1:0] cond_stick(
      input logic [15:0] raw,
      input logic [15:0] center,
      input logic [9:0]  limit,
      input logic [9:0]  dead
   );
      logic signed [16:0]       diff;
      logic signed [16:0]       lim_s;
      logic signed [CHAN_W-1:0] val;
      logic        [CHAN_W-1:0] mag;
      diff  = $signed({1'b0, raw}) - $signed({1'b0, center});
      lim_s = $signed({7'd0, limit});
      if (diff > lim_s) begin
         val = $signed({1'b0, limit});
      end else if (diff < -lim_s) begin
         val = -$signed({1'b0, limit});
      end else begin
         val = diff[CHAN_W-1:0];
      end
      mag = val[CHAN_W-1] ? CHAN_W'(-val) : CHAN_W'(val);
      if (mag < {1'b0, dead}) begin
         val = '0;
      end
      return val;
   endfunction

   // throttle channel: remove base, clamp to 0..limit, then apply the floor
   function automatic logic [CHAN_W-1:0] cond_throttle(
      input logic [15:0] raw,
      input logic [15:0] base,
      input logic [10:0] limit,
      input logic [10:0] floor_val
   );
      logic signed [16:0]  diff;
      logic [CHAN_W-1:0]   val;
      diff = $signed({1'b0, raw}) - $signed({1'b0, base});
      if (diff > $signed({6'd0, limit})) begin
         val = limit;
      end else if (diff < 0) begin
         val = '0;
      end else begin
         val = diff[CHAN_W-1:0];
      end
      if (val < floor_val) begin
         val = '0;
      end else begin
         val = val - floor_val;
      end
      return val;
   endfunction

endpackage

@@ sv/rcfd_csr.sv @@
`timescale 1ns / 1ps
// configuration register file of the remote frame decoder
// uses rcfd_pkg for register indexes, reset values and cfg_type

module rcfd_csr
   import rcfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // register decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTER_OFFSET:  cfg_in.center_offset  = csr_wdata;
            CSR_STICK_LIMIT:    cfg_in.stick_limit    = csr_wdata[9:0];
            CSR_DEAD_ZONE:      cfg_in.dead_zone      = csr_wdata[9:0];
            CSR_THROTTLE_BASE:  cfg_in.throttle_base  = csr_wdata;
            CSR_THROTTLE_LIMIT: cfg_in.throttle_limit = csr_wdata[10:0];
            CSR_THROTTLE_FLOOR: cfg_in.throttle_floor = csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_offset  <= RST_CENTER_OFFSET;
         cfg_ff.stick_limit    <= RST_STICK_LIMIT;
         cfg_ff.dead_zone      <= RST_DEAD_ZONE;
         cfg_ff.throttle_base  <= RST_THROTTLE_BASE;
         cfg_ff.throttle_limit <= RST_THROTTLE_LIMIT;
         cfg_ff.throttle_floor <= RST_THROTTLE_FLOOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/rcfd_framer.sv @@
`timescale 1ns / 1ps
// byte framer: header hunt, raw channel assembly and running checksum
// uses rcfd_pkg for frame constants and frame_type

module rcfd_framer
   import rcfd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      byte_valid,
   input  logic [7:0] rx_byte,
   output logic      frame_valid,
   output frame_type frame
);

   logic [3:0]             pos_ff;
   logic [3:0]             pos_in;
   logic [7:0]             sum_ff;
   logic [7:0]             sum_in;
   raw_type [NUM_CHAN-1:0] raw_ff;
   logic [3:0]             pos_m1;
   logic [1:0]             chan_idx;
   logic                   data_beat;

   // channel slot of the current data byte
   assign pos_m1    = pos_ff - 4'd1;
   assign chan_idx  = pos_m1[2:1];
   assign data_beat = byte_valid && (pos_ff != POS_HUNT) && (pos_ff != POS_LAST);

   // position and checksum sequencing
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (byte_valid) begin
         if (pos_ff == POS_HUNT) begin
            if (rx_byte == HEADER_BYTE) begin
               pos_in = 4'd1;
               sum_in = rx_byte;
            end
         end else if (pos_ff == POS_LAST) begin
            pos_in = POS_HUNT;
            sum_in = '0;
         end else begin
            pos_in = pos_ff + 4'd1;
            sum_in = sum_ff + rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   // raw channel bytes, big-endian, high byte first
   always_ff @(posedge clock) begin
      if (data_beat) begin
         if (pos_ff[0]) begin
            raw_ff[chan_idx] <= {rx_byte, 8'h00};
         end else begin
            raw_ff[chan_idx][7:0] <= rx_byte;
         end
      end
   end

   // checksum beat closes the frame
   assign frame_valid = byte_valid && (pos_ff == POS_LAST);
   assign frame.good  = (rx_byte == sum_ff);
   assign frame.raw   = raw_ff;

   // a stray byte while hunting leaves the framer hunting
   a_hunt_stays: assert property (@(posedge clock) disable iff (reset)
      byte_valid && (pos_ff == POS_HUNT) && (rx_byte != HEADER_BYTE) |=> pos_ff == POS_HUNT)
      else $error("framer left hunt without a header");

   // every checksum beat returns to hunt with a cleared sum
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      frame_valid |=> (pos_ff == POS_HUNT) && (sum_ff == 8'd0))
      else $error("framer did not rearm after frame end");

endmodule

@@ sv/rcfd_cond.sv @@
`timescale 1ns / 1ps
// frame stage and channel conditioning with the held value store
// uses rcfd_pkg for cfg_type, frame_type, chan_type and the conditioning functions

module rcfd_cond
   import rcfd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      frame_valid,
   input  frame_type frame,
   output logic      in_ready,
   output logic      out_valid,
   input  logic      out_ready,
   output chan_type  out_chan,
   output logic      out_good
);

   logic      ev_valid_ff;
   logic      ev_valid_in;
   frame_type ev_ff;
   chan_type  held_ff;
   chan_type  held_in;
   chan_type  fresh;
   logic      ev_adv;

   // stage handshake
   assign ev_adv   = ev_valid_ff && out_ready;
   assign in_ready = !ev_valid_ff || out_ready;

   always_comb begin
      ev_valid_in = ev_valid_ff;
      if (frame_valid) begin
         ev_valid_in = 1'b1;
      end else if (ev_adv) begin
         ev_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
      end else begin
         ev_valid_ff <= ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_valid) begin
         ev_ff <= frame;
      end
   end

   // conditioning of the four channels
   always_comb begin
      fresh.chan_zero  = cond_stick(ev_ff.raw[0], cfg.center_offset, cfg.stick_limit,
                                    cfg.dead_zone);
      fresh.chan_one   = cond_stick(ev_ff.raw[1], cfg.center_offset, cfg.stick_limit,
                                    cfg.dead_zone);
      fresh.chan_two   = cond_throttle(ev_ff.raw[2], cfg.throttle_base, cfg.throttle_limit,
                                       cfg.throttle_floor);
      fresh.chan_three = cond_stick(ev_ff.raw[3], cfg.center_offset, cfg.stick_limit,
                                    cfg.dead_zone);
   end

   // held values only move on a good checksum
   assign held_in = ev_ff.good ? fresh : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (ev_adv) begin
         held_ff <= held_in;
      end
   end

   assign out_valid = ev_valid_ff;
   assign out_chan  = held_in;
   assign out_good  = ev_ff.good;

   // stale frames and idle cycles never touch the held values
   a_held_stale: assert property (@(posedge clock) disable iff (reset)
      !(ev_adv && ev_ff.good) |=> $stable(held_ff))
      else $error("held values changed without a good frame");

   // a stalled frame keeps its slot and payload
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      ev_valid_ff && !out_ready |=> ev_valid_ff && $stable(ev_ff))
      else $error("frame stage lost a stalled frame");

endmodule

@@ sv/rcfd_outreg.sv @@
`timescale 1ns / 1ps
// result register in front of the response channel
// uses rcfd_pkg for chan_type

module rcfd_outreg
   import rcfd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  chan_type in_chan,
   input  logic     in_good,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output chan_type rsp_chan,
   output logic     rsp_good
);

   logic     valid_ff;
   logic     valid_in;
   chan_type chan_ff;
   logic     good_ff;

   // free when empty or when the current beat leaves
   assign in_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         chan_ff <= in_chan;
         good_ff <= in_good;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_chan  = chan_ff;
   assign rsp_good  = good_ff;

endmodule

@@ sv/rc_remote_frame_decoder.sv @@
`timescale 1ns / 1ps
// top level of the remote frame decoder
// uses rcfd_pkg, rcfd_csr, rcfd_framer, rcfd_cond and rcfd_outreg

// Takes one received byte per beat on req_ and accepts a byte every cycle while the
// result side keeps up. Bytes are dropped until the 0xAA header; the next eight bytes
// form four big-endian channels and the tenth is an 8-bit sum of the nine before it.
// Only the checksum byte produces a result. The frame is registered in the frame
// stage, where the channels are conditioned, and then moves into the result register,
// from which the held channel values are presented on rsp_. rsp_tuser is high if the
// checksum matched and the values were refreshed, low if they are stale. When
// rsp_tready is held low, one finished frame waits in the result register and a second
// in the frame stage; only then does req_tready drop. Registers on csr_ are always
// taken and must be written while no frame result is pending.

module rc_remote_frame_decoder
   import rcfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input bytes
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] rx_byte
   // frame results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [10:0] chan_zero, [21:11] chan_one,
                                              // [32:22] chan_two, [43:33] chan_three,
                                              // [47:44] zero
   output logic                  rsp_tuser,   // [0] frame_good
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type   cfg;
   logic      byte_valid;
   logic      frame_valid;
   frame_type frame;
   logic      cond_valid;
   logic      cond_ready;
   chan_type  cond_chan;
   logic      cond_good;
   chan_type  rsp_chan;

   assign byte_valid = req_tvalid && req_tready;

   rcfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rcfd_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (byte_valid),
      .rx_byte     (req_tdata),
      .frame_valid (frame_valid),
      .frame       (frame)
   );

   rcfd_cond u_cond (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .frame_valid (frame_valid),
      .frame       (frame),
      .in_ready    (req_tready),
      .out_valid   (cond_valid),
      .out_ready   (cond_ready),
      .out_chan    (cond_chan),
      .out_good    (cond_good)
   );

   rcfd_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cond_valid),
      .in_ready  (cond_ready),
      .in_chan   (cond_chan),
      .in_good   (cond_good),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_chan  (rsp_chan),
      .rsp_good  (rsp_tuser)
   );

   // pack the result beat
   assign rsp_tdata = {(RSP_DATA_W - $bits(chan_type))'(0), rsp_chan};

endmodule
